// ===== hdl/mmpr_pkg.sv =====
// Package with the shared types and constants of the multi-modulus product residue block.
`timescale 1ns / 1ps
`default_nettype none
package mmpr_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 28;
   localparam int LANE_W  = 5;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_FACTOR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_MUL,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/multi_modulus_product_residue_top.sv =====
// Top level of the multi-modulus product residue block: command sequencer and result port.
`timescale 1ns / 1ps
`default_nettype none
// A load command gives no result. A factor command walks all LANES lanes
// through the lane memories, one lane at a time: a lane that is not updated
// passes through the read, check and finish steps, and a lane that is updated
// through the read, check, multiply and finish steps, where the bit-serial modular
// multiplier works one bit per cycle. busy stays high until the walk is over. A
// result appears on rsp_valid for exactly one cycle and cannot be held off.
module multi_modulus_product_residue_top #(
   parameter int LANES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic [mmpr_pkg::LANE_W-1:0]  req_lane,
   input  wire logic [mmpr_pkg::WORD_W-1:0]  req_value,
   input  wire logic [mmpr_pkg::INDEX_W-1:0] req_factor_index,
   input  wire logic                         csr_wr_en,
   input  wire logic [mmpr_pkg::INDEX_W-1:0] csr_wr_data,
   output logic                              rsp_valid,
   output logic [mmpr_pkg::INDEX_W-1:0]      rsp_seq_index,
   output logic [mmpr_pkg::WORD_W-1:0]       rsp_remainder,
   output logic                              rsp_is_minus_one
);

   localparam int W  = mmpr_pkg::WORD_W;
   localparam int IW = mmpr_pkg::INDEX_W;
   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CW = LW + 1;

   mmpr_pkg::state_type state_ff, state_in;

   logic [IW-1:0] batch_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [W-1:0]  f_ff, f_in;
   logic [CW-1:0] lane_ff, lane_in;
   logic [W-1:0]  p_ff, p_in;
   logic [W-1:0]  q_ff, q_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_seq_ff, rsp_seq_in;
   logic [W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic          rsp_m1_ff, rsp_m1_in;

   logic          accept;
   logic          load_ok;
   logic [IW:0]   seq_n;
   logic [IW:0]   target;
   logic          do_update;
   logic          last_lane;

   logic          wr_en;
   logic          wr_mod_en;
   logic [LW-1:0] wr_addr;
   logic [W-1:0]  wr_prod;
   logic          rd_en;
   logic [W-1:0]  rd_prod;
   logic [W-1:0]  rd_mod;
   logic          mul_start;
   logic [W-1:0]  mul_b;
   logic          mul_done;
   logic [W-1:0]  mul_result;

   // Lane bookkeeping shared by the next-state and output logic.
   always_comb begin
      accept    = start && !busy;
      load_ok   = 32'(req_lane) < 32'(LANES);
      seq_n     = {1'b0, batch_ff} + (IW + 1)'(lane_ff);
      target    = {1'b0, idx_ff} + (IW + 1)'(1);
      do_update = (seq_n > {1'b0, idx_ff}) && (rd_mod != '0);
      last_lane = lane_ff == CW'(LANES - 1);
      mul_b     = (rd_mod == W'(1)) ? '0 : rd_prod;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmpr_pkg::ST_IDLE: begin
            if (accept && req_type == mmpr_pkg::REQ_FACTOR) begin
               state_in = mmpr_pkg::ST_READ;
            end
         end
         mmpr_pkg::ST_READ: begin
            state_in = mmpr_pkg::ST_CHECK;
         end
         mmpr_pkg::ST_CHECK: begin
            state_in = do_update ? mmpr_pkg::ST_MUL : mmpr_pkg::ST_FINISH;
         end
         mmpr_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = mmpr_pkg::ST_FINISH;
            end
         end
         mmpr_pkg::ST_FINISH: begin
            state_in = last_lane ? mmpr_pkg::ST_IDLE : mmpr_pkg::ST_READ;
         end
         default: begin
            state_in = mmpr_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: memory accesses, multiplier start and results.
   always_comb begin
      busy         = state_ff != mmpr_pkg::ST_IDLE;
      wr_en        = 1'b0;
      wr_mod_en    = 1'b0;
      wr_addr      = lane_ff[LW-1:0];
      wr_prod      = mul_result;
      rd_en        = 1'b0;
      mul_start    = 1'b0;
      idx_in       = idx_ff;
      f_in         = f_ff;
      lane_in      = lane_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      rsp_valid_in = 1'b0;
      rsp_seq_in   = rsp_seq_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_m1_in    = rsp_m1_ff;
      case (state_ff)
         mmpr_pkg::ST_IDLE: begin
            wr_addr = LW'(req_lane);
            wr_prod = W'(1);
            if (accept && req_type == mmpr_pkg::REQ_LOAD && load_ok) begin
               wr_en     = 1'b1;
               wr_mod_en = 1'b1;
            end
            if (accept && req_type == mmpr_pkg::REQ_FACTOR) begin
               idx_in  = req_factor_index;
               f_in    = req_value;
               lane_in = '0;
            end
         end
         mmpr_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         mmpr_pkg::ST_CHECK: begin
            p_in      = rd_prod;
            q_in      = rd_mod;
            mul_start = do_update;
         end
         mmpr_pkg::ST_MUL: begin
            if (mul_done) begin
               wr_en = 1'b1;
               p_in  = mul_result;
            end
         end
         mmpr_pkg::ST_FINISH: begin
            if (seq_n == target) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = seq_n[IW-1:0];
               rsp_rem_in   = p_ff;
               rsp_m1_in    = (q_ff != '0) && (p_ff == q_ff - W'(1));
            end
            lane_in = lane_ff + CW'(1);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Control and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmpr_pkg::ST_IDLE;
         batch_ff     <= '0;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            batch_ff <= csr_wr_data;
         end
      end
      idx_ff     <= idx_in;
      f_ff       <= f_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      rsp_seq_ff <= rsp_seq_in;
      rsp_rem_ff <= rsp_rem_in;
      rsp_m1_ff  <= rsp_m1_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seq_index    = rsp_seq_ff;
   assign rsp_remainder    = rsp_rem_ff;
   assign rsp_is_minus_one = rsp_m1_ff;

   mmpr_lane_store #(
      .LANES (LANES),
      .LW    (LW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_mod_en (wr_mod_en),
      .wr_addr   (wr_addr),
      .wr_prod   (wr_prod),
      .wr_mod    (req_value),
      .rd_en     (rd_en),
      .rd_addr   (lane_ff[LW-1:0]),
      .rd_prod   (rd_prod),
      .rd_mod    (rd_mod)
   );

   mmpr_mulmod u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_a      (f_ff),
      .mul_b      (mul_b),
      .mul_q      (rd_mod),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

`ifndef SYNTHESIS
   // A result transfer only follows the finish step of a lane.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == mmpr_pkg::ST_FINISH))
      else $error("result without a finished lane");

   // The multiplier only completes while the sequencer waits for it.
   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == mmpr_pkg::ST_MUL)
      else $error("multiplier done outside the multiply step");

   // The lane counter stays inside the lane range during a walk.
   a_lane_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> 32'(lane_ff) < 32'(LANES))
      else $error("lane counter out of range");

   // Memory writes never happen during the read or check steps.
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmpr_pkg::ST_READ || state_ff == mmpr_pkg::ST_CHECK) |-> !wr_en)
      else $error("write during a lane read");
`endif

endmodule
`default_nettype wire

// ===== hdl/mmpr_mulmod.sv =====
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mmpr_mulmod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        mul_start,
   input  wire logic [mmpr_pkg::WORD_W-1:0] mul_a,
   input  wire logic [mmpr_pkg::WORD_W-1:0] mul_b,
   input  wire logic [mmpr_pkg::WORD_W-1:0] mul_q,
   output logic                             mul_done,
   output logic [mmpr_pkg::WORD_W-1:0]      mul_result
);

   localparam int W  = mmpr_pkg::WORD_W;
   localparam int SW = $clog2(W) + 1;

   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  q_ff, q_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [W+1:0]  sum;
   logic [W+1:0]  sub1;
   logic [W+1:0]  sub2;

   // One step: r = (2r + bit * b) mod q; the sum stays below 3q.
   always_comb begin
      sum  = {1'b0, r_ff, 1'b0} + (a_ff[W-1] ? {2'b00, b_ff} : '0);
      sub1 = sum - {2'b00, q_ff};
      sub2 = sum - {1'b0, q_ff, 1'b0};
   end

   // Step sequencing and operand capture.
   always_comb begin
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (mul_start) begin
         r_in   = '0;
         a_in   = mul_a;
         b_in   = mul_b;
         q_in   = mul_q;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!sub2[W+1]) begin
            r_in = sub2[W-1:0];
         end else if (!sub1[W+1]) begin
            r_in = sub1[W-1:0];
         end else begin
            r_in = sum[W-1:0];
         end
         a_in   = {a_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + SW'(1);
         if (cnt_ff == SW'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
      q_ff <= q_in;
   end

   assign mul_done   = done_ff;
   assign mul_result = r_ff;

endmodule
`default_nettype wire

// ===== hdl/mmpr_lane_store.sv =====
// Lane memories for the running products and the moduli, with product valid bits.
`timescale 1ns / 1ps
`default_nettype none
module mmpr_lane_store #(
   parameter int LANES = 32,
   parameter int LW    = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic                        wr_mod_en,
   input  wire logic [LW-1:0]               wr_addr,
   input  wire logic [mmpr_pkg::WORD_W-1:0] wr_prod,
   input  wire logic [mmpr_pkg::WORD_W-1:0] wr_mod,
   input  wire logic                        rd_en,
   input  wire logic [LW-1:0]               rd_addr,
   output logic [mmpr_pkg::WORD_W-1:0]      rd_prod,
   output logic [mmpr_pkg::WORD_W-1:0]      rd_mod
);

   localparam int W = mmpr_pkg::WORD_W;

   logic [W-1:0]     prod_mem [LANES];
   logic [W-1:0]     mod_mem  [LANES];
   logic [LANES-1:0] valid_ff;
   logic [W-1:0]     prod_rd_ff;
   logic [W-1:0]     mod_rd_ff;
   logic             rd_valid_ff;

   // Product valid bits: an unwritten product reads as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Synchronous memories with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prod_mem[wr_addr] <= wr_prod;
      end
      if (wr_en && wr_mod_en) begin
         mod_mem[wr_addr] <= wr_mod;
      end
      if (rd_en) begin
         prod_rd_ff  <= prod_mem[rd_addr];
         mod_rd_ff   <= mod_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_prod = rd_valid_ff ? prod_rd_ff : W'(1);
   assign rd_mod  = mod_rd_ff;

endmodule
`default_nettype wire
